>>> sv/llh_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and helpers of the log2 latency histogram
// no dependencies; imported by both interfaces and the top level

package llh_pkg;

	localparam int LLH_POOL_SLOTS = 5;
	localparam int LLH_BUCKETS    = 64;
	localparam int LLH_TYPE_CODES = 128;

	localparam logic [63:0] LLH_ALL_ONES = '1;

	typedef logic [6:0]  type_code_t;
	typedef logic [5:0]  bkt_t;
	typedef logic [2:0]  slot_t;
	typedef logic [31:0] bkt_cnt_t;
	typedef logic [63:0] ns_t;

	typedef enum logic {
		OP_RECORD = 1'b0,
		OP_READ   = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_ZERO    = 2'd1,
		ST_FULL    = 2'd2,
		ST_UNKNOWN = 2'd3
	} status_t;

	typedef struct packed {
		op_t        opcode;
		type_code_t dist_type;
		ns_t        sample_ns;
		bkt_t       read_bucket;
	} in_item_t;

	typedef struct packed {
		status_t  status;
		slot_t    slot;
		bkt_t     bucket;
		bkt_cnt_t bucket_count;
		ns_t      min_ns;
		ns_t      max_ns;
		ns_t      total_ns;
		ns_t      sample_count;
	} out_item_t;

	// index of the highest set bit, zero for an input of zero or one
	function automatic bkt_t top_bit(input ns_t v);
		bkt_t b;
		b = '0;
		for (int i = 1; i < 64; i++) begin
			if (v[i]) begin
				b = bkt_t'(i);
			end
		end
		return b;
	endfunction

endpackage

>>> sv/llh_in_if.sv
`timescale 1ns / 1ps
// valid/ready channel carrying one sample or read request word
// depends on llh_pkg

interface llh_in_if import llh_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> sv/llh_out_if.sv
`timescale 1ns / 1ps
// valid/ready channel carrying one result word
// depends on llh_pkg

interface llh_out_if import llh_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> sv/latency_log2_histogram.sv
`timescale 1ns / 1ps
// log2 bucket latency histogram, top level
// depends on llh_pkg, llh_in_if, llh_out_if and llh_bucket_ram
//
//  channel   dir   handshake      word
//  samples   in    valid/ready    opcode, dist_type, sample_ns, read_bucket
//  results   out   valid/ready    status, slot, bucket, bucket_count, stats
//
// one word per cycle while results are taken and no sweep runs; the type map
// is read at acceptance, then the bucket counter read and the result register
// after reset a zeroing sweep over all POOL_SLOTS*64 words (320 by default)
// of the bucket store runs; samples.ready stays low until it ends
// each stage moves when the one after it is empty or moving, so a stalled
// result still lets new words fill the empty stages

module latency_log2_histogram import llh_pkg::*; #(
	parameter int POOL_SLOTS = LLH_POOL_SLOTS
) (
	input logic       clk,
	input logic       arst_n,
	llh_in_if.sink    samples,
	llh_out_if.source results
);

	localparam int    SLOT_IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
	localparam int    BKT_W      = $clog2(LLH_BUCKETS);
	localparam int    ADDR_W     = SLOT_IDX_W + BKT_W;
	localparam int    DEPTH      = POOL_SLOTS * LLH_BUCKETS;
	localparam slot_t POOL_MAX   = slot_t'(POOL_SLOTS);

	// handshake and stage moves
	logic en_out, en2, en1, acc, mv1, mv2, clr_busy;

	// type map
	slot_t                     map_mem [LLH_TYPE_CODES];
	logic [LLH_TYPE_CODES-1:0] map_vld_q;
	slot_t                     slots_used_q;

	// stage 1
	logic     v_s1;
	in_item_t item_s1;
	slot_t    map_rd_s1;
	logic     map_vld_s1;
	logic     map_fwd_s1;
	slot_t    fwd_slot_s1;

	logic    bound;
	slot_t   slot_lk;
	status_t st_c;
	slot_t   slot_c;
	bkt_t    bkt_c;
	logic    upd_c, bind_c, show_stats_c, show_cnt_c, bind_go;

	// stage 2
	logic    v_s2;
	status_t st_s2;
	slot_t   slot_s2;
	bkt_t    bkt_s2;
	ns_t     val_s2;
	logic    upd_s2, show_stats_s2, show_cnt_s2;

	logic [SLOT_IDX_W-1:0] sidx_s2;
	bkt_cnt_t              cur_cnt, inc_cnt;
	ns_t                   mn, mx, sm, ct, new_mn, new_mx, new_sm, new_ct;
	out_item_t             res_c;

	// per-slot statistics
	ns_t min_q   [POOL_SLOTS];
	ns_t max_q   [POOL_SLOTS];
	ns_t sum_q   [POOL_SLOTS];
	ns_t count_q [POOL_SLOTS];

	// result register
	logic      res_v_q;
	out_item_t res_q;

	assign en_out        = !res_v_q || results.ready;
	assign en2           = !v_s2 || en_out;
	assign en1           = !v_s1 || en2;
	assign samples.ready = en1 && !clr_busy;
	assign acc           = samples.valid && samples.ready;
	assign mv1           = v_s1 && en2;
	assign mv2           = v_s2 && en_out;

	// ---------------- stage 1: map lookup and classification ----------------

	always_ff @(posedge clk) begin
		if (bind_go) begin
			map_mem[item_s1.dist_type] <= slots_used_q;
		end
		if (acc) begin
			item_s1     <= samples.data;
			map_rd_s1   <= map_mem[samples.data.dist_type];
			fwd_slot_s1 <= slots_used_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			map_vld_s1   <= 1'b0;
			map_fwd_s1   <= 1'b0;
			map_vld_q    <= '0;
			slots_used_q <= '0;
		end else begin
			if (en1) begin
				v_s1 <= acc;
			end
			if (acc) begin
				map_vld_s1 <= map_vld_q[samples.data.dist_type];
				// the word leaving stage 1 may bind this very type right now
				map_fwd_s1 <= bind_go && (item_s1.dist_type == samples.data.dist_type);
			end
			if (bind_go) begin
				map_vld_q[item_s1.dist_type] <= 1'b1;
				slots_used_q                 <= slots_used_q + 1'b1;
			end
		end
	end

	assign bound   = map_fwd_s1 || map_vld_s1;
	assign slot_lk = map_fwd_s1 ? fwd_slot_s1 : map_rd_s1;

	always_comb begin
		st_c         = ST_OK;
		slot_c       = '0;
		bkt_c        = '0;
		upd_c        = 1'b0;
		bind_c       = 1'b0;
		show_stats_c = 1'b0;
		show_cnt_c   = 1'b0;
		priority if (item_s1.opcode == OP_READ) begin
			bkt_c = item_s1.read_bucket;
			if (bound) begin
				slot_c       = slot_lk;
				show_stats_c = 1'b1;
				show_cnt_c   = 1'b1;
			end else begin
				st_c = ST_UNKNOWN;
			end
		end else if (item_s1.sample_ns == '0) begin
			st_c = ST_ZERO;
			if (bound) begin
				slot_c       = slot_lk;
				show_stats_c = 1'b1;
			end
		end else begin
			bkt_c = top_bit(item_s1.sample_ns);
			if (bound) begin
				slot_c       = slot_lk;
				upd_c        = 1'b1;
				show_stats_c = 1'b1;
				show_cnt_c   = 1'b1;
			end else if (slots_used_q >= POOL_MAX) begin
				st_c = ST_FULL;
			end else begin
				slot_c       = slots_used_q;
				bind_c       = 1'b1;
				upd_c        = 1'b1;
				show_stats_c = 1'b1;
				show_cnt_c   = 1'b1;
			end
		end
	end

	assign bind_go = mv1 && bind_c;

	llh_bucket_ram #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_bucket_ram (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (mv1),
		.rd_addr  ({slot_c[SLOT_IDX_W-1:0], bkt_c}),
		.rd_data  (cur_cnt),
		.wr_en    (mv2 && upd_s2),
		.wr_addr  ({sidx_s2, bkt_s2}),
		.wr_data  (inc_cnt),
		.clr_busy (clr_busy)
	);

	// ---------------- stage 2: counter and statistics update ----------------

	always_ff @(posedge clk) begin
		if (mv1) begin
			st_s2         <= st_c;
			slot_s2       <= slot_c;
			bkt_s2        <= bkt_c;
			val_s2        <= item_s1.sample_ns;
			upd_s2        <= upd_c;
			show_stats_s2 <= show_stats_c;
			show_cnt_s2   <= show_cnt_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	assign sidx_s2 = slot_s2[SLOT_IDX_W-1:0];
	assign inc_cnt = cur_cnt + 32'd1;
	assign mn      = min_q[sidx_s2];
	assign mx      = max_q[sidx_s2];
	assign sm      = sum_q[sidx_s2];
	assign ct      = count_q[sidx_s2];
	assign new_mn  = (val_s2 < mn) ? val_s2 : mn;
	assign new_mx  = (val_s2 > mx) ? val_s2 : mx;
	assign new_sm  = sm + val_s2;
	assign new_ct  = ct + 64'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < POOL_SLOTS; i++) begin
				min_q[i]   <= LLH_ALL_ONES;
				max_q[i]   <= '0;
				sum_q[i]   <= '0;
				count_q[i] <= '0;
			end
		end else if (mv2 && upd_s2) begin
			min_q[sidx_s2]   <= new_mn;
			max_q[sidx_s2]   <= new_mx;
			sum_q[sidx_s2]   <= new_sm;
			count_q[sidx_s2] <= new_ct;
		end
	end

	always_comb begin
		res_c.status       = st_s2;
		res_c.slot         = slot_s2;
		res_c.bucket       = bkt_s2;
		res_c.bucket_count = '0;
		res_c.min_ns       = LLH_ALL_ONES;
		res_c.max_ns       = '0;
		res_c.total_ns     = '0;
		res_c.sample_count = '0;
		if (show_cnt_s2) begin
			res_c.bucket_count = upd_s2 ? inc_cnt : cur_cnt;
		end
		if (show_stats_s2) begin
			res_c.min_ns       = upd_s2 ? new_mn : mn;
			res_c.max_ns       = upd_s2 ? new_mx : mx;
			res_c.total_ns     = upd_s2 ? new_sm : sm;
			res_c.sample_count = upd_s2 ? new_ct : ct;
		end
	end

	// ---------------- result register ----------------

	always_ff @(posedge clk) begin
		if (mv2) begin
			res_q <= res_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (en_out) begin
			res_v_q <= v_s2;
		end
	end

	assign results.valid = res_v_q;
	assign results.data  = res_q;

	// ---------------- checks ----------------

	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		slots_used_q <= POOL_MAX)
		else $error("slot pool count past its size");

	a_bind_room: assert property (@(posedge clk) disable iff (!arst_n)
		bind_go |-> slots_used_q < POOL_MAX)
		else $error("type bound with no free slot");

	a_sweep_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !samples.ready)
		else $error("word accepted during bucket sweep");

	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.data.status == ST_FULL
		|-> results.data.sample_count == '0 && results.data.bucket_count == '0)
		else $error("dropped sample reports slot contents");

	a_ok_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.data.status == ST_OK
		|-> results.data.sample_count != '0)
		else $error("bound slot reports no samples");

endmodule

>>> sv/llh_bucket_ram.sv
`timescale 1ns / 1ps
// bucket counter store: one write and one registered read port, a zeroing
// sweep after reset, and a bypass for a write landing on the word being read

module llh_bucket_ram #(
	parameter int DEPTH  = 320,
	parameter int ADDR_W = 9
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [31:0]       rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [31:0]       wr_data,
	output logic              clr_busy
);

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

	logic [31:0]       mem [DEPTH];
	logic [31:0]       rd_q;
	logic              fwd_q;
	logic [31:0]       fwd_data_q;
	logic              clr_busy_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic              we;
	logic [ADDR_W-1:0] wa;
	logic [31:0]       wd;

	// sweep takes the port over any write; the top level accepts nothing until it ends
	assign we = clr_busy_q | wr_en;
	assign wa = clr_busy_q ? clr_addr_q : wr_addr;
	assign wd = clr_busy_q ? '0 : wr_data;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == LAST_ADDR) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// same-edge write to the read address is missed by the array read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_data_q <= wr_data;
		end
	end

	assign rd_data  = fwd_q ? fwd_data_q : rd_q;
	assign clr_busy = clr_busy_q;

endmodule
